### hdl/distance_led_bar_renderer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the distance LED bar renderer
// Shared clocking and reset for concurrent checks.
// ----------------------------------------------------------------------------
`ifndef DISTANCE_LED_BAR_RENDERER_ASSERT_SVH
`define DISTANCE_LED_BAR_RENDERER_ASSERT_SVH

// property must hold at every clock edge out of reset
`define DLBR_ASSERT_HOLDS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DLBR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/dlbr_pkg.sv
// ----------------------------------------------------------------------------
// dlbr_pkg
// Types and constants shared by the distance LED bar renderer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dlbr_pkg;

    localparam int DIST_W     = 16;
    localparam int IDX_W      = 6;
    localparam int COL_W      = 3;
    localparam int STAT_W     = 3;
    localparam int BLINK_W    = 4;
    localparam int CFG_ADDR_W = 2;
    localparam int PROD_W     = DIST_W + IDX_W;
    localparam int DIV_STEPS  = IDX_W;
    localparam int STEP_W     = 3;

    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_DISTANCE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_DISTANCE = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_BLINK_PERIOD = 2'd2;

    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    localparam logic [STAT_W-1:0] SENSOR_OK           = 3'd0;
    localparam logic [STAT_W-1:0] SENSOR_OUT_OF_RANGE = 3'd2;

    localparam logic [COL_W-1:0] COL_OFF    = 3'd0;
    localparam logic [COL_W-1:0] COL_ORANGE = 3'd1;
    localparam logic [COL_W-1:0] COL_BLUE   = 3'd2;
    localparam logic [COL_W-1:0] COL_RED    = 3'd3;
    localparam logic [COL_W-1:0] COL_GREEN  = 3'd4;

    localparam logic [BLINK_W-1:0] BLINK_SAT       = 4'd15;
    localparam logic [BLINK_W-1:0] BLINK_PERIOD_RST = 4'd5;
    localparam logic [DIST_W-1:0]  MIN_DIST_RST     = 16'd100;
    localparam logic [DIST_W-1:0]  MAX_DIST_RST     = 16'd500;
    localparam logic [3:0]         EMERG_LAST_PHASE = 4'd9;

    typedef struct packed {
        logic              op;
        logic [STAT_W-1:0] sensor_status;
        logic [DIST_W-1:0] dist_mm;
    } item_word_t;

    typedef struct packed {
        logic [IDX_W-1:0] pixel_index;
        logic [COL_W-1:0] pixel_colour;
        logic             frame_last;
    } pixel_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_UPDATE,
        ST_LOAD,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic mul;
        logic div_step;
        logic update;
        logic load;
    } dp_cmd_t;

    typedef struct packed {
        logic have_meas;
        logic div_last;
        logic word_last;
    } dp_status_t;

endpackage

`default_nettype wire

### hdl/dlbr_ctrl.sv
// ----------------------------------------------------------------------------
// dlbr_ctrl
// Sequencer: capture, scale, update state, then stream one frame; a tick taken before any measurement starts no frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dlbr_ctrl
    import dlbr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    input  wire logic       item_op,
    output logic            item_stall,
    output logic            pixel_valid,
    input  wire logic       pixel_stall,
    input  wire dp_status_t stat,
    output dp_cmd_t         cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid && (item_op == OP_MEASURE || stat.have_meas))
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (stat.div_last)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!pixel_stall && stat.word_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        item_stall  = 1'b1;
        pixel_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                item_stall  = 1'b0;
                cmd.capture = item_valid;
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            ST_LOAD:
            begin
                cmd.load = 1'b1;
            end
            ST_EMIT:
            begin
                pixel_valid = 1'b1;
                cmd.load    = !pixel_stall && !stat.word_last;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/dlbr_datapath.sv
// ----------------------------------------------------------------------------
// dlbr_datapath
// Configuration, held measurement, index scaler, animation state, pixel word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dlbr_datapath
    import dlbr_pkg::*;
#(
    parameter int STRIP_LENGTH = 40
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [DIST_W-1:0]     cfg_wr_data,
    input  wire item_word_t            item,
    output pixel_word_t                pixel,
    input  wire dp_cmd_t               cmd,
    output dp_status_t                 stat
);

    localparam int ZONE_SIZE_I = (STRIP_LENGTH * 10) / 100;
    localparam int ZONE_CTR_I  = (STRIP_LENGTH * 30) / 100;
    localparam int ZONE_HALF_I = ZONE_SIZE_I / 2;
    localparam int ZONE_LO_I   = (ZONE_CTR_I >= ZONE_HALF_I) ? ZONE_CTR_I - ZONE_HALF_I : 0;
    localparam int ZONE_HI_I   = (ZONE_SIZE_I == 0) ? ZONE_LO_I : ZONE_LO_I + ZONE_SIZE_I - 1;

    localparam logic [IDX_W-1:0]  ZONE_LO   = IDX_W'(ZONE_LO_I);
    localparam logic [IDX_W-1:0]  ZONE_HI   = IDX_W'(ZONE_HI_I);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(STRIP_LENGTH - 1);
    localparam logic [IDX_W:0]    STRIP_LEN = (IDX_W + 1)'(STRIP_LENGTH);
    localparam logic [STEP_W-1:0] STEP_TOP  = STEP_W'(DIV_STEPS - 1);

    logic [DIST_W-1:0]  min_reg, max_reg;
    logic [BLINK_W-1:0] period_reg;
    logic               op_reg;
    logic [STAT_W-1:0]  status_reg;
    logic [DIST_W-1:0]  dist_reg;
    logic               have_reg;

    logic [PROD_W-1:0]  rem_reg, rem_next;
    logic [IDX_W-1:0]   quo_reg, quo_next;
    logic [STEP_W-1:0]  step_reg;

    logic [IDX_W-1:0]   pos_reg, pos_next;
    logic [IDX_W-1:0]   start_reg, start_next;
    logic [IDX_W-1:0]   end_reg, end_next;
    logic               active_reg, active_next;
    logic               fwd_reg, fwd_next;
    logic               lit_reg, lit_next;
    logic [BLINK_W-1:0] tss_reg, tss_next;

    logic [IDX_W-1:0]   pix_reg;
    logic [3:0]         phase_reg;
    pixel_word_t        word_reg, word_next;

    logic               status_ok, ge_min, le_max;
    logic               span_hit, under_min, above_max;
    logic [DIST_W-1:0]  range_w, offset_w;
    logic [PROD_W-1:0]  divisor_shift;
    logic [IDX_W-1:0]   idx;
    logic               idx_in_zone;
    logic [BLINK_W-1:0] tss_inc;
    logic [COL_W-1:0]   colour;

    // classify the held measurement
    always_comb
    begin
        status_ok = (status_reg == SENSOR_OK);
        ge_min    = (dist_reg >= min_reg);
        le_max    = (dist_reg <= max_reg);
        span_hit  = status_ok && ge_min && le_max;
        under_min = status_ok && !ge_min;
        above_max = status_ok && ge_min && !le_max;
        range_w   = max_reg - min_reg;
        offset_w  = dist_reg - min_reg;
    end

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        divisor_shift = PROD_W'(range_w) << step_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        if (rem_reg >= divisor_shift)
        begin
            rem_next           = rem_reg - divisor_shift;
            quo_next[step_reg] = 1'b1;
        end
    end

    always_comb
    begin
        if (range_w == '0)
        begin
            idx = '0;
        end
        else if ({1'b0, quo_reg} >= STRIP_LEN)
        begin
            idx = LAST_IDX;
        end
        else
        begin
            idx = quo_reg;
        end
        idx_in_zone = (idx >= ZONE_LO) && (idx <= ZONE_HI);
    end

    // animation and blink update
    always_comb
    begin
        pos_next    = pos_reg;
        start_next  = start_reg;
        end_next    = end_reg;
        active_next = active_reg;
        fwd_next    = fwd_reg;
        lit_next    = lit_reg;
        tss_next    = tss_reg;
        tss_inc     = (tss_reg == BLINK_SAT) ? BLINK_SAT : tss_reg + 1'b1;

        if (op_reg == OP_MEASURE)
        begin
            if (status_ok)
            begin
                if (span_hit && idx < ZONE_LO)
                begin
                    if (!active_reg || !fwd_reg)
                    begin
                        pos_next    = '0;
                        fwd_next    = 1'b1;
                        start_next  = '0;
                        end_next    = ZONE_LO;
                        active_next = 1'b1;
                    end
                end
                else if ((span_hit && idx > ZONE_HI) || above_max)
                begin
                    if (!active_reg || fwd_reg)
                    begin
                        pos_next    = LAST_IDX;
                        fwd_next    = 1'b0;
                        start_next  = LAST_IDX;
                        end_next    = ZONE_HI;
                        active_next = 1'b1;
                    end
                end
                else
                begin
                    active_next = 1'b0;
                end
            end
            else if (status_reg != SENSOR_OUT_OF_RANGE)
            begin
                active_next = 1'b0;
            end
        end
        else
        begin
            if (tss_inc >= period_reg)
            begin
                lit_next = !lit_reg;
                tss_next = '0;
            end
            else
            begin
                tss_next = tss_inc;
            end

            if (above_max && (!active_reg || fwd_reg))
            begin
                pos_next    = LAST_IDX;
                fwd_next    = 1'b0;
                start_next  = LAST_IDX;
                end_next    = ZONE_HI;
                active_next = 1'b1;
            end
            else if (active_reg)
            begin
                if (fwd_reg)
                begin
                    pos_next = pos_reg + 1'b1;
                    if (pos_next >= end_reg)
                    begin
                        pos_next = start_reg;
                    end
                end
                else if (pos_reg <= end_reg)
                begin
                    pos_next = start_reg;
                end
                else
                begin
                    pos_next = pos_reg - 1'b1;
                end
            end
        end
    end

    // colour of the pixel at pix_reg, layers in priority order
    always_comb
    begin
        colour = COL_OFF;
        if (active_reg && span_hit && pos_reg == pix_reg)
        begin
            colour = fwd_reg ? COL_ORANGE : COL_BLUE;
        end
        else if (above_max && pos_reg == pix_reg)
        begin
            colour = COL_BLUE;
        end

        if (span_hit)
        begin
            if (idx_in_zone)
            begin
                if (pix_reg >= ZONE_LO && pix_reg <= ZONE_HI)
                begin
                    colour = COL_RED;
                end
            end
            else if (pix_reg == idx)
            begin
                colour = COL_GREEN;
            end
        end

        if (under_min && lit_reg && phase_reg == '0)
        begin
            colour = COL_RED;
        end

        word_next.pixel_index  = pix_reg;
        word_next.pixel_colour = colour;
        word_next.frame_last   = (pix_reg == LAST_IDX);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg    <= MIN_DIST_RST;
            max_reg    <= MAX_DIST_RST;
            period_reg <= BLINK_PERIOD_RST;
            status_reg <= '0;
            dist_reg   <= '0;
            have_reg   <= 1'b0;
            pos_reg    <= '0;
            start_reg  <= '0;
            end_reg    <= '0;
            active_reg <= 1'b0;
            fwd_reg    <= 1'b0;
            lit_reg    <= 1'b0;
            tss_reg    <= BLINK_SAT;
            step_reg   <= '0;
            pix_reg    <= '0;
            phase_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    CFG_MIN_DISTANCE: min_reg    <= cfg_wr_data;
                    CFG_MAX_DISTANCE: max_reg    <= cfg_wr_data;
                    CFG_BLINK_PERIOD: period_reg <= cfg_wr_data[BLINK_W-1:0];
                    default:          period_reg <= period_reg;
                endcase
            end

            if (cmd.capture && item.op == OP_MEASURE)
            begin
                status_reg <= item.sensor_status;
                dist_reg   <= item.dist_mm;
                have_reg   <= 1'b1;
            end

            if (cmd.mul)
            begin
                step_reg <= STEP_TOP;
            end
            else if (cmd.div_step && step_reg != '0)
            begin
                step_reg <= step_reg - 1'b1;
            end

            if (cmd.update)
            begin
                pos_reg    <= pos_next;
                start_reg  <= start_next;
                end_reg    <= end_next;
                active_reg <= active_next;
                fwd_reg    <= fwd_next;
                lit_reg    <= lit_next;
                tss_reg    <= tss_next;
                pix_reg    <= '0;
                phase_reg  <= '0;
            end
            else if (cmd.load)
            begin
                pix_reg   <= pix_reg + 1'b1;
                phase_reg <= (phase_reg == EMERG_LAST_PHASE) ? 4'd0 : phase_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= item.op;
        end
        if (cmd.mul)
        begin
            rem_reg <= PROD_W'(offset_w) * PROD_W'(LAST_IDX);
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        if (cmd.load)
        begin
            word_reg <= word_next;
        end
    end

    assign pixel          = word_reg;
    assign stat.have_meas = have_reg;
    assign stat.div_last  = (step_reg == '0);
    assign stat.word_last = word_reg.frame_last;

endmodule

`default_nettype wire

### hdl/distance_led_bar_renderer.sv
// Sequence: an accepted item passes the scale, divide, update and load states before
//   the first pixel word; STRIP_LENGTH words follow, one per cycle without stall.
// Items: no new item is taken until the last word of the frame is accepted; the
//   divider has 6 steps; a tick before any measurement is taken and makes no frame.
// Reset: rst_n is asynchronous; it loads the register defaults (100, 500, 5),
//   clears the animation and held measurement and presets the blink counter to 15.
// ----------------------------------------------------------------------------
// distance_led_bar_renderer
// Maps distance words and frame ticks to a stream of per-LED colour words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module distance_led_bar_renderer
    import dlbr_pkg::*;
#(
    parameter int STRIP_LENGTH = 40
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [DIST_W-1:0]     cfg_wr_data,
    input  wire logic                  item_valid,
    output logic                       item_stall,
    input  wire item_word_t            item,
    output logic                       pixel_valid,
    input  wire logic                  pixel_stall,
    output pixel_word_t                pixel
);

    dp_cmd_t    cmd;
    dp_status_t stat;

    dlbr_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_op     (item.op),
        .item_stall  (item_stall),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .stat        (stat),
        .cmd         (cmd)
    );

    dlbr_datapath #(
        .STRIP_LENGTH (STRIP_LENGTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .item        (item),
        .pixel       (pixel),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

`default_nettype wire

### hdl/dlbr_checker.sv
// ----------------------------------------------------------------------------
// dlbr_checker
// Port-level checks on the frame stream of the distance LED bar renderer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "distance_led_bar_renderer_assert.svh"

module dlbr_checker
    import dlbr_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        item_stall,
    input wire logic        pixel_valid,
    input wire logic        pixel_stall,
    input wire pixel_word_t pixel
);

    `DLBR_ASSERT_HOLDS(a_no_take_while_emit, !pixel_valid || item_stall, "item taken during frame")
    `DLBR_ASSERT_NEXT(a_stall_holds, pixel_valid && pixel_stall, pixel_valid && $stable(pixel), "stalled word changed")
    `DLBR_ASSERT_NEXT(a_frame_continues, pixel_valid && !pixel_stall && !pixel.frame_last, pixel_valid, "frame broken off")
    `DLBR_ASSERT_NEXT(a_frame_ends, pixel_valid && !pixel_stall && pixel.frame_last, !pixel_valid, "word after frame end")

endmodule

bind distance_led_bar_renderer dlbr_checker u_dlbr_checker (.*);

`default_nettype wire

### verif/distance_led_bar_renderer_test.sv
// ----------------------------------------------------------------------------
// distance_led_bar_renderer_test
// Self-checking bench for the LED bar renderer: drives distance and tick words
// under random gaps and output stalls, predicts every frame in a scoreboard
// class and compares each pixel word in order, across several register sets.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class frame_tracker #(int LEDS = 40);

    localparam int ZONE_SIZE   = (LEDS * 10) / 100;
    localparam int ZONE_CENTRE = (LEDS * 30) / 100;
    localparam int ZONE_HALF   = ZONE_SIZE / 2;
    localparam int ZONE_LO     = (ZONE_CENTRE >= ZONE_HALF) ? ZONE_CENTRE - ZONE_HALF : 0;
    localparam int ZONE_HI     = (ZONE_SIZE == 0) ? ZONE_LO : ZONE_LO + ZONE_SIZE - 1;
    localparam int BLINK_STEP  = 10;

    logic [15:0] lo_mm;
    logic [15:0] hi_mm;
    logic [3:0]  blink_period;

    logic [5:0]  sweep_pos;
    logic [5:0]  sweep_from;
    logic [5:0]  sweep_to;
    bit          sweep_on;
    bit          sweep_up;
    bit          flash_lit;
    logic [3:0]  tick_count;
    logic [2:0]  last_status;
    logic [15:0] last_mm;
    bit          measured;

    dlbr_pkg::pixel_word_t due_pixels[$];
    int errors;
    int words_checked;
    int frames_predicted;

    function new();
        lo_mm        = dlbr_pkg::MIN_DIST_RST;
        hi_mm        = dlbr_pkg::MAX_DIST_RST;
        blink_period = dlbr_pkg::BLINK_PERIOD_RST;
        sweep_pos    = '0;
        sweep_from   = '0;
        sweep_to     = '0;
        sweep_on     = 1'b0;
        sweep_up     = 1'b0;
        flash_lit    = 1'b0;
        tick_count   = dlbr_pkg::BLINK_SAT;
        last_status  = '0;
        last_mm      = '0;
        measured     = 1'b0;
        errors       = 0;
        words_checked = 0;
        frames_predicted = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
        case (idx)
            dlbr_pkg::CFG_MIN_DISTANCE: lo_mm = val;
            dlbr_pkg::CFG_MAX_DISTANCE: hi_mm = val;
            dlbr_pkg::CFG_BLINK_PERIOD: blink_period = val[3:0];
            default: ;
        endcase
    endfunction

    function int unsigned classify(output bit hit, output bit below, output bit above);
        int unsigned span;
        int unsigned offs;
        int unsigned idx;
        hit      = 1'b0;
        below    = 1'b0;
        above    = 1'b0;
        idx      = 0;
        if (last_status != dlbr_pkg::SENSOR_OK)
            return 0;
        if (last_mm >= lo_mm && last_mm <= hi_mm)
        begin
            span = int'(hi_mm) - int'(lo_mm);
            offs = int'(last_mm) - int'(lo_mm);
            if (span != 0)
                idx = (offs * (LEDS - 1)) / span;
            if (idx >= LEDS)
                idx = LEDS - 1;
            hit = 1'b1;
        end
        else if (last_mm < lo_mm)
            below = 1'b1;
        else
            above = 1'b1;
        return idx;
    endfunction

    function void start_far();
        sweep_pos  = 6'(LEDS - 1);
        sweep_up   = 1'b0;
        sweep_from = sweep_pos;
        sweep_to   = 6'(ZONE_HI);
        sweep_on   = 1'b1;
    endfunction

    function void start_close();
        sweep_pos  = '0;
        sweep_up   = 1'b1;
        sweep_from = '0;
        sweep_to   = 6'(ZONE_LO);
        sweep_on   = 1'b1;
    endfunction

    function void advance_sweep();
        if (!sweep_on)
            return;
        if (sweep_up)
        begin
            sweep_pos = sweep_pos + 6'd1;
            if (sweep_pos >= sweep_to)
                sweep_pos = sweep_from;
        end
        else if (sweep_pos <= sweep_to)
            sweep_pos = sweep_from;
        else
            sweep_pos = sweep_pos - 6'd1;
    endfunction

    function void predict_frame();
        logic [2:0] colours [LEDS];
        bit inr;
        bit bel;
        bit abv;
        int unsigned idx;
        dlbr_pkg::pixel_word_t w;
        idx = classify(inr, bel, abv);
        for (int i = 0; i < LEDS; i++)
            colours[i] = dlbr_pkg::COL_OFF;
        if (sweep_on && inr)
        begin
            if (sweep_pos < LEDS)
                colours[sweep_pos] = sweep_up ? dlbr_pkg::COL_ORANGE : dlbr_pkg::COL_BLUE;
        end
        else if (abv)
        begin
            if (!sweep_on || sweep_up)
                start_far();
            if (sweep_pos < LEDS)
                colours[sweep_pos] = dlbr_pkg::COL_BLUE;
        end
        if (inr)
        begin
            if (idx >= ZONE_LO && idx <= ZONE_HI)
            begin
                for (int i = ZONE_LO; i <= ZONE_HI && i < LEDS; i++)
                    colours[i] = dlbr_pkg::COL_RED;
            end
            else
                colours[idx] = dlbr_pkg::COL_GREEN;
        end
        if (bel && flash_lit)
        begin
            for (int i = 0; i < LEDS; i += BLINK_STEP)
                colours[i] = dlbr_pkg::COL_RED;
        end
        for (int i = 0; i < LEDS; i++)
        begin
            w.pixel_index  = 6'(i);
            w.pixel_colour = colours[i];
            w.frame_last   = (i == LEDS - 1);
            due_pixels.push_back(w);
        end
        frames_predicted++;
    endfunction

    // returns 0 when the word produces no frame
    function bit take_item(dlbr_pkg::item_word_t w);
        bit inr;
        bit bel;
        bit abv;
        int unsigned idx;
        if (w.op == dlbr_pkg::OP_MEASURE)
        begin
            last_status = w.sensor_status;
            last_mm     = w.dist_mm;
            measured    = 1'b1;
            idx = classify(inr, bel, abv);
            if (last_status == dlbr_pkg::SENSOR_OK)
            begin
                if (inr)
                begin
                    if (idx < ZONE_LO)
                    begin
                        if (!sweep_on || !sweep_up)
                            start_close();
                    end
                    else if (idx > ZONE_HI)
                    begin
                        if (!sweep_on || sweep_up)
                            start_far();
                    end
                    else
                        sweep_on = 1'b0;
                end
                else if (bel)
                    sweep_on = 1'b0;
            end
            else if (last_status != dlbr_pkg::SENSOR_OUT_OF_RANGE)
                sweep_on = 1'b0;
            predict_frame();
            return 1'b1;
        end
        if (!measured)
            return 1'b0;
        advance_sweep();
        if (tick_count < dlbr_pkg::BLINK_SAT)
            tick_count = tick_count + 4'd1;
        if (tick_count >= blink_period)
        begin
            flash_lit  = !flash_lit;
            tick_count = '0;
        end
        predict_frame();
        return 1'b1;
    endfunction

    function void check_pixel(dlbr_pkg::pixel_word_t got);
        dlbr_pkg::pixel_word_t want;
        if (due_pixels.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected pixel word: idx %0d col %0d last %0b",
                         got.pixel_index, got.pixel_colour, got.frame_last);
            return;
        end
        want = due_pixels.pop_front();
        words_checked++;
        if (got.pixel_index !== want.pixel_index || got.pixel_colour !== want.pixel_colour ||
            got.frame_last !== want.frame_last)
        begin
            errors++;
            if (errors <= 10)
                $display("pixel mismatch: expected idx %0d col %0d last %0b, got idx %0d col %0d last %0b",
                         want.pixel_index, want.pixel_colour, want.frame_last,
                         got.pixel_index, got.pixel_colour, got.frame_last);
        end
    endfunction

endclass

module distance_led_bar_renderer_test;

    import dlbr_pkg::*;

    localparam int STRIP_LENGTH  = 40;
    localparam int CYCLE_LIMIT   = 800000;
    localparam int SETTLE_CYCLES = 64;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 80;

    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE       = 2'd3;
    localparam logic [STAT_W-1:0]     SENSOR_TIMEOUT  = 3'd1;
    localparam logic [STAT_W-1:0]     SENSOR_NO_ECHO  = 3'd3;
    localparam logic [STAT_W-1:0]     SENSOR_INVALID  = 3'd4;
    localparam logic [STAT_W-1:0]     SENSOR_RESERVED = 3'd7;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr    = '0;
    logic [DIST_W-1:0]     cfg_wr_data = '0;
    logic                  item_valid  = 1'b0;
    logic                  item_stall;
    item_word_t            item        = '0;
    logic                  pixel_valid;
    logic                  pixel_stall = 1'b0;
    pixel_word_t           pixel;

    frame_tracker #(STRIP_LENGTH) tracker;

    int cycle_count  = 0;
    int gap_odds     = 25;
    int stall_odds   = 25;
    int stall_left   = 0;
    bit quiet_tail   = 1'b0;
    int items_sent   = 0;
    int items_idle   = 0;
    int settings_run = 1;

    always #6 clk = ~clk;

    distance_led_bar_renderer #(
        .STRIP_LENGTH(STRIP_LENGTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr(cfg_addr),
        .cfg_wr_data(cfg_wr_data),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .pixel_valid(pixel_valid),
        .pixel_stall(pixel_stall),
        .pixel(pixel)
    );

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d pixel words still due",
                     cycle_count, tracker.due_pixels.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pixel_valid && !pixel_stall)
            tracker.check_pixel(pixel);
    end

    always @(negedge clk)
    begin
        if (stall_left > 0)
            stall_left--;
        else if (!quiet_tail && $urandom_range(0, 99) < stall_odds)
            stall_left = $urandom_range(1, 4);
        pixel_stall <= (stall_left > 0);
    end

    task automatic send_word(input item_word_t w);
        int gap;
        gap = 0;
        if (!quiet_tail && $urandom_range(0, 99) < gap_odds)
            gap = $urandom_range(1, 4);
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        if (!tracker.take_item(w))
            items_idle++;
        items_sent++;
    endtask

    // hold the input idle until every predicted word has arrived
    task automatic drain_frames();
        @(negedge clk);
        item_valid <= 1'b0;
        while (tracker.due_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [DIST_W-1:0] val);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        tracker.set_reg(idx, val);
    endtask

    task automatic apply_setting(input logic [15:0] lo, input logic [15:0] hi,
                                 input logic [3:0] blink);
        write_reg(CFG_MIN_DISTANCE, lo);
        write_reg(CFG_MAX_DISTANCE, hi);
        write_reg(CFG_BLINK_PERIOD, {12'($urandom), blink});
        settings_run++;
    endtask

    function automatic item_word_t measure(input logic [2:0] status, input logic [15:0] mm);
        item_word_t w;
        w.op            = OP_MEASURE;
        w.sensor_status = status;
        w.dist_mm       = mm;
        return w;
    endfunction

    function automatic item_word_t tick_word();
        item_word_t w;
        w.op            = OP_TICK;
        w.sensor_status = 3'($urandom);
        w.dist_mm       = 16'($urandom);
        return w;
    endfunction

    function automatic logic [15:0] pick_distance(input logic [15:0] lo, input logic [15:0] hi);
        int unsigned lo_u;
        int unsigned hi_u;
        int unsigned d;
        lo_u = lo;
        hi_u = hi;
        case ($urandom_range(0, 9))
            0, 1, 2: d = $urandom_range(lo_u, hi_u);
            3: d = (lo_u <= hi_u) ? lo_u + ((hi_u - lo_u) * $urandom_range(9, 14)) / 39 : lo_u;
            4: d = lo_u;
            5: d = hi_u;
            6: d = (lo_u == 0) ? 0 : $urandom_range(0, lo_u - 1);
            7: d = (hi_u == 65535) ? hi_u : $urandom_range(hi_u + 1, 65535);
            default: d = $urandom_range(0, 65535);
        endcase
        return d[15:0];
    endfunction

    function automatic item_word_t random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return tick_word();
        if (r < 85)
            return measure(SENSOR_OK, pick_distance(tracker.lo_mm, tracker.hi_mm));
        return measure(3'($urandom), 16'($urandom));
    endfunction

    initial
    begin
        logic [15:0] lo;
        tracker = new();
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // defaults after reset
        send_word(tick_word());
        send_word(measure(SENSOR_OK, 16'd300));
        send_word(tick_word());
        send_word(measure(SENSOR_OK, 16'd100));
        send_word(tick_word());
        send_word(measure(SENSOR_OK, 16'd230));
        send_word(measure(SENSOR_OK, 16'd50));
        repeat (5) send_word(tick_word());
        send_word(measure(SENSOR_OK, 16'd600));
        send_word(tick_word());
        send_word(measure(SENSOR_OUT_OF_RANGE, 16'hFFFF));
        send_word(tick_word());
        send_word(measure(SENSOR_TIMEOUT, 16'd500));
        send_word(measure(SENSOR_NO_ECHO, 16'd0));
        send_word(measure(SENSOR_INVALID, 16'd1234));
        send_word(measure(SENSOR_RESERVED, 16'hFFFF));
        send_word(measure(SENSOR_OK, 16'd500));
        send_word(measure(SENSOR_OK, 16'd0));
        send_word(measure(SENSOR_OK, 16'hFFFF));

        // zero range, blink on every tick, spare index ignored
        drain_frames();
        apply_setting(16'd250, 16'd250, 4'd0);
        write_reg(CFG_SPARE, 16'hFFFF);
        send_word(measure(SENSOR_OK, 16'd250));
        send_word(tick_word());
        send_word(measure(SENSOR_OK, 16'd249));
        send_word(tick_word());
        send_word(tick_word());

        for (int p = 0; p < PHASES; p++)
        begin
            drain_frames();
            case (p)
                0: apply_setting(16'd0, 16'hFFFF, 4'd1);
                1: apply_setting(16'd300, 16'd300, 4'd0);
                2: apply_setting(16'd600, 16'd200, 4'd15);
                3: apply_setting(16'd0, 16'd39, 4'd3);
                4: apply_setting(16'hFFFF, 16'hFFFF, 4'd2);
                default:
                begin
                    lo = 16'($urandom_range(0, 2000));
                    apply_setting(lo, lo + 16'($urandom_range(40, 3000)),
                                  4'($urandom_range(0, 15)));
                end
            endcase
            gap_odds   = 25 * $urandom_range(0, 2);
            stall_odds = 25 * $urandom_range(0, 2);
            if (p == PHASES - 1)
                quiet_tail = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2)
                    drain_frames();
                send_word(random_item());
            end
        end

        drain_frames();
        $display("sent %0d words (%0d ticks before any measurement), %0d register sets",
                 items_sent, items_idle, settings_run);
        $display("predicted %0d frames, checked %0d pixel words, %0d mismatches",
                 tracker.frames_predicted, tracker.words_checked, tracker.errors);
        if (tracker.errors == 0 && tracker.due_pixels.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/dlbr_pkg.sv
hdl/dlbr_ctrl.sv
hdl/dlbr_datapath.sv
hdl/distance_led_bar_renderer.sv
hdl/dlbr_checker.sv
verif/distance_led_bar_renderer_test.sv
